>>> src/lbph_pkg.sv
// shared constants and types for the lbp histogram block
`timescale 1ns / 1ps

package lbph_pkg;

  localparam int MAX_ROW_WIDTH_DEF  = 1024;
  localparam int BIN_COUNT_BITS_DEF = 32;
  localparam int NUM_BINS           = 256;
  localparam int BIN_W              = 8;
  localparam int PIX_W              = 8;
  localparam int REQ_W              = 2;
  localparam int CFG_W              = 11;
  localparam int OUT_CNT_W          = 32;
  localparam int ROW_WIDTH_RST      = 50;
  localparam int FIFO_DEPTH         = 4;
  localparam int FIFO_AW            = 2;
  localparam int FIFO_CW            = 3;

  localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic                 code_valid;
    logic [BIN_W-1:0]     lbp_code;
    logic [OUT_CNT_W-1:0] bin_count;
  } out_item_t;

endpackage

>>> src/lbph_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module lbph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/lbp_histogram_3x3_unit.sv
// top level: streaming 3x3 local binary pattern histogram
// a result passes the stage 1 and stage 2 registers, then is written to the output queue
// throughput: one item per cycle while the output queue has room, set by the histogram
//   read-modify-write on a ram with registered read (same-bin updates are forwarded)
// reset: synchronous; clears position counters, window, histogram valid bits
//   and the output queue, row width goes to 50; line stores are not cleared
`timescale 1ns / 1ps

module lbp_histogram_3x3_unit #(
  parameter int MAX_ROW_WIDTH  = lbph_pkg::MAX_ROW_WIDTH_DEF,
  parameter int BIN_COUNT_BITS = lbph_pkg::BIN_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lbph_pkg::CFG_W-1:0]  cfg_data,   // row_width
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // pixel_value, bin_index
  input  logic [lbph_pkg::REQ_W-1:0]  in_tuser,   // req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,  // lbp_code, bin_count
  output logic                        out_tuser   // code_valid
);

  localparam int COL_W = $clog2(MAX_ROW_WIDTH);
  localparam int WID_W = $clog2(MAX_ROW_WIDTH + 1);
  localparam int WRST_I = (lbph_pkg::ROW_WIDTH_RST < 3) ? 3 :
                          ((lbph_pkg::ROW_WIDTH_RST > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH :
                           lbph_pkg::ROW_WIDTH_RST);
  localparam logic [WID_W-1:0] WIDTH_RST = WID_W'(WRST_I);
  localparam int PW = lbph_pkg::PIX_W;
  localparam int BW = lbph_pkg::BIN_W;

  // configuration
  logic [WID_W-1:0] width_r;
  logic [WID_W-1:0] width_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (32'(cfg_data) < 32'd3) begin
      width_nxt = WID_W'(3);
    end else if (32'(cfg_data) > 32'(MAX_ROW_WIDTH)) begin
      width_nxt = WID_W'(MAX_ROW_WIDTH);
    end else begin
      width_nxt = WID_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      width_r <= width_nxt;
    end
  end

  // input transfer and position counters
  logic                         in_acc;
  logic [lbph_pkg::REQ_W-1:0]   req_in;
  logic [PW-1:0]                pix_in;
  logic [BW-1:0]                bin_in;
  logic [COL_W-1:0]             col_r;
  logic [COL_W-1:0]             col_nxt;
  logic [1:0]                   row_r;
  logic [1:0]                   row_nxt;
  logic [COL_W:0]               col_inc;
  logic                         code_en;

  assign in_acc  = in_tvalid && in_tready;
  assign req_in  = in_tuser;
  assign pix_in  = in_tdata[7:0];
  assign bin_in  = in_tdata[15:8];
  assign col_inc = {1'b0, col_r} + (COL_W+1)'(1);
  assign code_en = (row_r == 2'd2) && (32'(col_r) >= 32'd2);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      case (req_in)
        lbph_pkg::REQ_PIXEL: begin
          if (32'(col_inc) >= 32'(width_r)) begin
            col_nxt = '0;
            row_nxt = (row_r == 2'd2) ? row_r : row_r + 2'd1;
          end else begin
            col_nxt = col_inc[COL_W-1:0];
          end
        end
        lbph_pkg::REQ_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line store data returns, window shifts, code forms
  logic                       s1_v_r;
  logic [lbph_pkg::REQ_W-1:0] s1_req_r;
  logic [PW-1:0]              s1_pix_r;
  logic [BW-1:0]              s1_bin_r;
  logic [COL_W-1:0]           s1_col_r;
  logic                       s1_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
    s1_req_r <= req_in;
    s1_pix_r <= pix_in;
    s1_bin_r <= bin_in;
    s1_col_r <= col_r;
    s1_en_r  <= code_en;
  end

  logic [PW-1:0] up_q;
  logic [PW-1:0] mid_q;
  logic          ls_we;

  assign ls_we = s1_v_r && (s1_req_r == lbph_pkg::REQ_PIXEL);

  lbph_ram #(.WIDTH(PW), .DEPTH(MAX_ROW_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (ls_we),
    .waddr (s1_col_r),
    .wdata (mid_q),
    .raddr (col_r),
    .rdata (up_q)
  );

  lbph_ram #(.WIDTH(PW), .DEPTH(MAX_ROW_WIDTH)) u_line_middle (
    .clk   (clk),
    .we    (ls_we),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .raddr (col_r),
    .rdata (mid_q)
  );

  logic [PW-1:0] win_r   [3][3];
  logic [PW-1:0] win_sh  [3][3];
  logic [PW-1:0] win_nxt [3][3];
  logic [BW-1:0] code1;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_sh[r][0] = win_r[r][1];
      win_sh[r][1] = win_r[r][2];
    end
    win_sh[0][2] = up_q;
    win_sh[1][2] = mid_q;
    win_sh[2][2] = s1_pix_r;
  end

  always_comb begin
    win_nxt = win_r;
    if (s1_v_r) begin
      case (s1_req_r)
        lbph_pkg::REQ_PIXEL: win_nxt = win_sh;
        lbph_pkg::REQ_CLEAR: begin
          for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
              win_nxt[r][k] = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // neighbors clockwise from top left
  always_comb begin
    code1[0] = win_sh[0][0] > win_sh[1][1];
    code1[1] = win_sh[0][1] > win_sh[1][1];
    code1[2] = win_sh[0][2] > win_sh[1][1];
    code1[3] = win_sh[1][2] > win_sh[1][1];
    code1[4] = win_sh[2][2] > win_sh[1][1];
    code1[5] = win_sh[2][1] > win_sh[1][1];
    code1[6] = win_sh[2][0] > win_sh[1][1];
    code1[7] = win_sh[1][0] > win_sh[1][1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[r][k] <= '0;
        end
      end
    end else begin
      win_r <= win_nxt;
    end
  end

  // histogram read issued from stage 1
  logic [BW-1:0] hist_raddr;

  assign hist_raddr = (s1_req_r == lbph_pkg::REQ_PIXEL) ? code1 : s1_bin_r;

  // stage 2: histogram read-modify-write and result
  logic                       s2_v_r;
  logic [lbph_pkg::REQ_W-1:0] s2_req_r;
  logic                       s2_en_r;
  logic [BW-1:0]              s2_addr_r;
  logic                       s2_fwd_r;
  logic [BIN_COUNT_BITS-1:0]  s2_fval_r;
  logic                       s2_hv_r;
  logic [BIN_COUNT_BITS-1:0]  hist_q;
  logic [BIN_COUNT_BITS-1:0]  cur_cnt;
  logic [BIN_COUNT_BITS-1:0]  inc_cnt;
  logic                       hist_we;
  logic                       hist_clr;
  logic [lbph_pkg::NUM_BINS-1:0] hv_r;
  lbph_pkg::out_item_t        s2_item;

  assign cur_cnt  = s2_fwd_r ? s2_fval_r : (s2_hv_r ? hist_q : '0);
  assign inc_cnt  = (&cur_cnt) ? cur_cnt : cur_cnt + BIN_COUNT_BITS'(1);
  assign hist_we  = s2_v_r && (s2_req_r == lbph_pkg::REQ_PIXEL) && s2_en_r;
  assign hist_clr = s2_v_r && (s2_req_r == lbph_pkg::REQ_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_req_r  <= s1_req_r;
    s2_en_r   <= s1_en_r;
    s2_addr_r <= hist_raddr;
    s2_fwd_r  <= hist_clr || (hist_we && (s2_addr_r == hist_raddr));
    s2_fval_r <= hist_clr ? '0 : inc_cnt;
    s2_hv_r   <= hv_r[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
    end else if (hist_clr) begin
      hv_r <= '0;
    end else if (hist_we) begin
      hv_r[s2_addr_r] <= 1'b1;
    end
  end

  lbph_ram #(.WIDTH(BIN_COUNT_BITS), .DEPTH(lbph_pkg::NUM_BINS)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (s2_addr_r),
    .wdata (inc_cnt),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  always_comb begin
    s2_item.code_valid = hist_we;
    s2_item.lbp_code   = hist_we ? s2_addr_r : '0;
    s2_item.bin_count  = (s2_req_r == lbph_pkg::REQ_READ) ?
                         lbph_pkg::OUT_CNT_W'(cur_cnt) : '0;
  end

  // output queue, sized to cover every item in flight
  lbph_pkg::out_item_t          fifo_r [lbph_pkg::FIFO_DEPTH];
  logic [lbph_pkg::FIFO_AW-1:0] wptr_r;
  logic [lbph_pkg::FIFO_AW-1:0] rptr_r;
  logic [lbph_pkg::FIFO_CW-1:0] cnt_r;
  logic [lbph_pkg::FIFO_CW-1:0] occ;
  logic                         pop;
  lbph_pkg::out_item_t          head;

  assign pop        = out_tvalid && out_tready;
  assign occ        = cnt_r + lbph_pkg::FIFO_CW'(s1_v_r) + lbph_pkg::FIFO_CW'(s2_v_r);
  assign in_tready  = occ < lbph_pkg::FIFO_CW'(lbph_pkg::FIFO_DEPTH);
  assign out_tvalid = cnt_r != '0;
  assign head       = fifo_r[rptr_r];
  assign out_tuser  = head.code_valid;
  assign out_tdata  = {head.bin_count, head.lbp_code};

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      fifo_r[wptr_r] <= s2_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (s2_v_r) begin
        wptr_r <= wptr_r + lbph_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + lbph_pkg::FIFO_AW'(1);
      end
      case ({s2_v_r, pop})
        2'b10:   cnt_r <= cnt_r + lbph_pkg::FIFO_CW'(1);
        2'b01:   cnt_r <= cnt_r - lbph_pkg::FIFO_CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
